// ----- src/bwrm_pkg.sv -----
package bwrm_pkg;

  localparam int BP_ENTRIES  = 8;
  localparam int WP_ENTRIES  = 8;
  localparam int INSTR_BYTES = 4;

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 64;
  localparam int SIZE_W = 16;

  localparam logic [CMD_W-1:0] CMD_SET_BP    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_WP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHK_FETCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHK_DATA  = 3'd4;

  localparam int BP_CNT_W = $clog2(BP_ENTRIES + 1);
  localparam int WP_CNT_W = $clog2(WP_ENTRIES + 1);
  localparam int BP_IDX_W = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int WP_IDX_W = (WP_ENTRIES > 1) ? $clog2(WP_ENTRIES) : 1;

  // comparator lanes cover the larger table; min tree works in groups of four
  localparam int TBL_ENTRIES = (BP_ENTRIES > WP_ENTRIES) ? BP_ENTRIES : WP_ENTRIES;
  localparam int GRP         = 4;
  localparam int NGRP        = (TBL_ENTRIES + GRP - 1) / GRP;
  localparam int TBL_PAD     = NGRP * GRP;

  typedef struct packed {
    logic              en;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] endp;
    logic              szero;
  } tbl_op_t;

  typedef struct packed {
    logic                                full;
    logic [TBL_ENTRIES-1:0]              match;
    logic [TBL_ENTRIES-1:0][ADDR_W-1:0]  cand;
  } probe_t;

  typedef struct packed {
    logic              v;
    logic [ADDR_W-1:0] a;
  } cand_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
  endfunction

  function automatic cand_t pick_min(input cand_t x, input cand_t y);
    if (x.v && (!y.v || (x.a <= y.a))) begin
      return x;
    end
    return y;
  endfunction

endpackage

// ----- src/bwrm_in_if.sv -----
interface bwrm_in_if import bwrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] size;

  modport source (output valid, output cmd, output address, output size, input ready);
  modport sink   (input valid, input cmd, input address, input size, output ready);
endinterface

// ----- src/bwrm_out_if.sv -----
interface bwrm_out_if import bwrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [ADDR_W-1:0] match_address;
  logic              table_full;

  modport source (output valid, output hit, output match_address, output table_full,
                  input ready);
  modport sink   (input valid, input hit, input match_address, input table_full,
                  output ready);
endinterface

// ----- src/bwrm_tables.sv -----
module bwrm_tables import bwrm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  tbl_op_t op,
  output probe_t  probe
);

  logic [ADDR_W-1:0]   bp_lo_r [BP_ENTRIES];
  logic [ADDR_W-1:0]   bp_hi_r [BP_ENTRIES];
  logic [ADDR_W-1:0]   wp_lo_r [WP_ENTRIES];
  logic [ADDR_W-1:0]   wp_hi_r [WP_ENTRIES];
  logic [BP_CNT_W-1:0] bp_cnt_r, bp_cnt_nxt;
  logic [WP_CNT_W-1:0] wp_cnt_r, wp_cnt_nxt;

  logic bp_full, wp_full, is_fetch, is_data;
  logic              match_w [TBL_ENTRIES];
  logic [ADDR_W-1:0] cand_w  [TBL_ENTRIES];

  assign bp_full  = (bp_cnt_r == BP_CNT_W'(BP_ENTRIES));
  assign wp_full  = (wp_cnt_r == WP_CNT_W'(WP_ENTRIES));
  assign is_fetch = (op.cmd == CMD_CHK_FETCH);
  assign is_data  = (op.cmd == CMD_CHK_DATA) && !op.szero;

  always_comb begin
    bp_cnt_nxt = bp_cnt_r;
    wp_cnt_nxt = wp_cnt_r;
    if (op.en) begin
      unique case (op.cmd)
        CMD_SET_BP: if (!bp_full) bp_cnt_nxt = bp_cnt_r + 1'b1;
        CMD_SET_WP: if (!wp_full) wp_cnt_nxt = wp_cnt_r + 1'b1;
        CMD_CLEAR: begin
          bp_cnt_nxt = '0;
          wp_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_cnt_r <= '0;
      wp_cnt_r <= '0;
    end else begin
      bp_cnt_r <= bp_cnt_nxt;
      wp_cnt_r <= wp_cnt_nxt;
    end
  end

  // range storage: append at the current count
  always_ff @(posedge clk) begin
    if (op.en && (op.cmd == CMD_SET_BP) && !bp_full) begin
      bp_lo_r[bp_cnt_r[BP_IDX_W-1:0]] <= op.addr;
      bp_hi_r[bp_cnt_r[BP_IDX_W-1:0]] <= op.endp;
    end
    if (op.en && (op.cmd == CMD_SET_WP) && !wp_full) begin
      wp_lo_r[wp_cnt_r[WP_IDX_W-1:0]] <= op.addr;
      wp_hi_r[wp_cnt_r[WP_IDX_W-1:0]] <= op.endp;
    end
  end

  // one comparator lane per entry; overlap of [addr, endp] with [lo, hi]
  for (genvar i = 0; i < TBL_ENTRIES; i++) begin : g_ent
    logic bp_m, wp_m;
    logic [ADDR_W-1:0] wp_c;
    if (i < BP_ENTRIES) begin : g_bp
      assign bp_m = (BP_CNT_W'(i) < bp_cnt_r) && (bp_lo_r[i] <= op.endp) &&
                    (bp_hi_r[i] >= op.addr);
    end else begin : g_nobp
      assign bp_m = 1'b0;
    end
    if (i < WP_ENTRIES) begin : g_wp
      assign wp_m = (WP_CNT_W'(i) < wp_cnt_r) && (wp_lo_r[i] <= op.endp) &&
                    (wp_hi_r[i] >= op.addr);
      assign wp_c = (wp_lo_r[i] > op.addr) ? wp_lo_r[i] : op.addr;
    end else begin : g_nowp
      assign wp_m = 1'b0;
      assign wp_c = '0;
    end
    assign match_w[i] = (is_fetch && bp_m) || (is_data && wp_m);
    assign cand_w[i]  = wp_c;
  end

  always_comb begin
    probe.full = ((op.cmd == CMD_SET_BP) && bp_full) || ((op.cmd == CMD_SET_WP) && wp_full);
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      probe.match[i] = match_w[i];
      probe.cand[i]  = cand_w[i];
    end
  end

endmodule

// ----- src/breakpoint_watchpoint_range_matcher.sv -----
// Breakpoint / watchpoint range matcher. Holds up to BP_ENTRIES instruction
// breakpoint ranges and WP_ENTRIES data watchpoint ranges (inclusive byte
// ranges, end addresses saturate at the top of the 64-bit space). Every item
// gives exactly one result: set commands report table_full when dropped,
// clear empties both tables, fetch checks report a hit on any overlap with
// PC..PC+INSTR_BYTES-1, data checks report a hit plus the lowest matching byte
// address. One item is accepted per cycle while in_ch.ready is high. The edge
// that accepts the item loads the input register, and the result then passes
// the end-address adder, the comparator lanes against the tables and the
// lowest-address tree, which has two registered levels; the second is the
// output register that offers the result.
// Table updates take effect at the comparator stage, so an item always sees
// every earlier set or clear. in_ch.ready drops only while a finished result
// is stalled at the output and every stage behind it is full; bubbles close up.
module breakpoint_watchpoint_range_matcher import bwrm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  bwrm_in_if.sink    in_ch,
  bwrm_out_if.source out_ch
);

  // stage handshake: a stage loads when empty or when the one ahead loads
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;

  assign rdy_out = !out_v_r || out_ch.ready;
  assign rdy4    = !s4_v_r || rdy_out;
  assign rdy3    = !s3_v_r || rdy4;
  assign rdy2    = !s2_v_r || rdy3;
  assign rdy1    = !s1_v_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)    s1_v_r  <= in_ch.valid;
      if (rdy2)    s2_v_r  <= s1_v_r;
      if (rdy3)    s3_v_r  <= s2_v_r;
      if (rdy4)    s4_v_r  <= s3_v_r;
      if (rdy_out) out_v_r <= s4_v_r;
    end
  end

  // stage 1: input register
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [SIZE_W-1:0] s1_size_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_addr_r <= in_ch.address;
      s1_size_r <= in_ch.size;
    end
  end

  // stage 2: end address of the range or access, one saturating add
  logic [ADDR_W-1:0] span_nxt, s2_end_nxt;
  logic [CMD_W-1:0]  s2_cmd_r;
  logic [ADDR_W-1:0] s2_addr_r, s2_end_r;
  logic              s2_szero_r;

  always_comb begin
    unique case (s1_cmd_r)
      CMD_SET_BP:
        span_nxt = (s1_size_r > SIZE_W'(INSTR_BYTES)) ? ADDR_W'(s1_size_r)
                                                       : ADDR_W'(INSTR_BYTES - 1);
      CMD_SET_WP:    span_nxt = ADDR_W'(s1_size_r);
      CMD_CHK_FETCH: span_nxt = ADDR_W'(INSTR_BYTES - 1);
      // zero-size access is flagged separately, so the wrap here is harmless
      CMD_CHK_DATA:  span_nxt = ADDR_W'(s1_size_r - 1'b1);
      default:       span_nxt = '0;
    endcase
    s2_end_nxt = sat_add(s1_addr_r, span_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_addr_r  <= s1_addr_r;
      s2_end_r   <= s2_end_nxt;
      s2_szero_r <= (s1_size_r == '0);
    end
  end

  // stage 3: table update and comparator lanes
  tbl_op_t op;
  probe_t  probe;

  assign op.en    = s2_v_r && rdy3;
  assign op.cmd   = s2_cmd_r;
  assign op.addr  = s2_addr_r;
  assign op.endp  = s2_end_r;
  assign op.szero = s2_szero_r;

  bwrm_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .probe (probe)
  );

  logic              s3_data_r, s3_full_r;
  cand_t             s3_cand_r [TBL_PAD];
  cand_t             s3_cand_nxt [TBL_PAD];

  always_comb begin
    for (int i = 0; i < TBL_PAD; i++) begin
      s3_cand_nxt[i] = '0;
    end
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      s3_cand_nxt[i].v = probe.match[i];
      s3_cand_nxt[i].a = probe.cand[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_data_r <= (s2_cmd_r == CMD_CHK_DATA);
      s3_full_r <= probe.full;
      for (int i = 0; i < TBL_PAD; i++) begin
        s3_cand_r[i] <= s3_cand_nxt[i];
      end
    end
  end

  // stage 4: lowest candidate within each group of four
  logic  s4_data_r, s4_full_r;
  cand_t s4_grp_r [NGRP];
  cand_t s4_grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      s4_grp_nxt[g] = pick_min(pick_min(s3_cand_r[g*GRP],     s3_cand_r[g*GRP + 1]),
                               pick_min(s3_cand_r[g*GRP + 2], s3_cand_r[g*GRP + 3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_data_r <= s3_data_r;
      s4_full_r <= s3_full_r;
      for (int g = 0; g < NGRP; g++) begin
        s4_grp_r[g] <= s4_grp_nxt[g];
      end
    end
  end

  // output register: merge groups, address only reported for data hits
  cand_t             best_nxt;
  logic              out_hit_r, out_full_r;
  logic [ADDR_W-1:0] out_maddr_r;

  always_comb begin
    best_nxt = s4_grp_r[0];
    for (int g = 1; g < NGRP; g++) begin
      best_nxt = pick_min(best_nxt, s4_grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && s4_v_r) begin
      out_hit_r   <= best_nxt.v;
      out_maddr_r <= (s4_data_r && best_nxt.v) ? best_nxt.a : '0;
      out_full_r  <= s4_full_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.match_address = out_maddr_r;
  assign out_ch.table_full    = out_full_r;

  // input side only backs up behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output backpressure");

  // a dropped set command (table_full) never reports a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.table_full))
    else $error("hit and table_full in one result");

  // a nonzero address only comes with a hit
  a_addr_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.match_address != '0)) |-> out_ch.hit)
    else $error("match_address without hit");

endmodule
